### sv/bal_pkg.sv
// Package: buddy allocator constants and payload types.
`timescale 1ns / 1ps
`default_nettype none
package bal_pkg;
    localparam int HeapOrder = 12;
    localparam int NodeCount = 1024;
    localparam int NodeW = 10;
    localparam int LinkW = 11;
    localparam int OrdW = 4;
    localparam int TagCount = 1 << (HeapOrder - 2);
    localparam int TagW = HeapOrder - 2;
    localparam logic [LinkW-1:0] NIL_NODE = LinkW'(NodeCount);
    localparam logic [0:0] KIND_ALLOC = 1'b0;
    localparam logic [0:0] KIND_FREE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [11:0] size;
        logic [11:0] address;
    } req_t;

    typedef struct packed {
        logic [11:0] address_res;
        logic        ok;
        logic [3:0]  order;
    } resp_t;
endpackage
`default_nettype wire

### sv/buddy_allocator.sv
// Top level: buddy allocator with a sequencer over node, spare and tag memories.
//
//  channel | ports          | direction | payload
//  s_      | s_valid/ready  | in        | bal_pkg::req_t  (kind, size, address)
//  m_      | m_valid/ready  | out       | bal_pkg::resp_t (address_res, ok, order)
//
// An oversize allocate goes straight to the result; an allocate scans the orders
// upward from the requested one and splits the found block down level by level.
// A free walks the list of its order node by node and merges level by level; the
// list walk is paced by the single read port of the node memories.
// One item is worked at a time; s_ready is low meanwhile.
// Reset is synchronous; a clearing pass over all 1024 tag entries then writes the order tags
// and node 0 with s_ready low. The spare pool reads as identity until written
// (tracked by a fill mark). A result waits in the output register while m_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bal_pkg::req_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bal_pkg::resp_t      m_data
);
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ASIZE = 5'd1;
    localparam logic [4:0] ST_ASCAN = 5'd2;
    localparam logic [4:0] ST_APOP  = 5'd3;
    localparam logic [4:0] ST_APOP2 = 5'd4;
    localparam logic [4:0] ST_SPL0  = 5'd5;
    localparam logic [4:0] ST_SPL1  = 5'd6;
    localparam logic [4:0] ST_SPL2  = 5'd7;
    localparam logic [4:0] ST_FTAG  = 5'd8;
    localparam logic [4:0] ST_FTAG2 = 5'd9;
    localparam logic [4:0] ST_FLVL  = 5'd10;
    localparam logic [4:0] ST_FRD   = 5'd11;
    localparam logic [4:0] ST_FCHK  = 5'd12;
    localparam logic [4:0] ST_FUNL  = 5'd13;
    localparam logic [4:0] ST_PUSH0 = 5'd14;
    localparam logic [4:0] ST_PUSH1 = 5'd15;
    localparam logic [4:0] ST_PUSH2 = 5'd16;
    localparam logic [4:0] ST_OUT   = 5'd17;
    localparam logic [4:0] ST_GIVE  = 5'd18;
    localparam logic [4:0] ST_CLR   = 5'd19;

    localparam int LW = bal_pkg::LinkW;
    localparam int NW = bal_pkg::NodeW;
    localparam int OW = bal_pkg::OrdW;
    localparam int HO = bal_pkg::HeapOrder;

    // memories
    logic [11:0]   node_block_mem [bal_pkg::NodeCount];
    logic [LW-1:0] node_link_mem  [bal_pkg::NodeCount];
    logic [NW-1:0] spare_mem      [bal_pkg::NodeCount];
    logic [OW-1:0] tag_mem        [bal_pkg::TagCount];

    logic [LW-1:0] list_head_reg [HO+1];
    logic [LW:0]   spare_top_reg;
    // spare entries at index >= fill_reg were never written and read as identity
    logic [LW-1:0] fill_reg;
    logic [bal_pkg::TagW-1:0] clr_reg;

    logic [4:0]    state_reg;
    logic          kind_reg;
    logic [11:0]   size_reg, off_reg;
    logic [OW-1:0] o_reg, h_reg;
    logic [LW-1:0] n_reg, prev_reg;
    logic [LW:0]   steps_reg;
    logic          ok_reg;
    bal_pkg::resp_t out_reg;
    logic          m_valid_reg;

    // read ports (registered data)
    logic [NW-1:0] nd_addr;
    logic [11:0]   nb_q;
    logic [LW-1:0] nl_q;
    logic [NW-1:0] sp_addr;
    logic [NW-1:0] sp_q;
    logic [LW-1:0] sp_idx_q;
    logic [bal_pkg::TagW-1:0] tg_addr;
    logic [OW-1:0] tg_q;

    logic [11:0] buddy;
    logic [NW-1:0] spare_node;
    logic [OW-1:0] tag_val;
    logic [12:0] vsum;
    logic [OW-1:0] blen;
    logic [LW:0] avail;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign spare_node = (sp_idx_q >= fill_reg) ? sp_idx_q[NW-1:0] : sp_q;
    assign tag_val = tg_q;
    assign buddy = off_reg ^ (12'd1 << h_reg);
    assign vsum = {1'b0, size_reg} + 13'd3;
    assign avail = (spare_top_reg <= (LW+1)'(bal_pkg::NodeCount)) ?
                   (LW+1)'(bal_pkg::NodeCount) - spare_top_reg : '0;

    always_comb begin
        blen = '0;
        for (int i = 0; i < 13; i++) begin
            if (vsum[i]) blen = OW'(i + 1);
        end
    end

    always_comb begin
        nd_addr = n_reg[NW-1:0];
        sp_addr = spare_top_reg[NW-1:0];
        tg_addr = off_reg[11:2];
    end

    always_ff @(posedge aclk) begin
        nb_q <= node_block_mem[nd_addr];
        nl_q <= node_link_mem[nd_addr];
        sp_q <= spare_mem[sp_addr];
        sp_idx_q <= spare_top_reg[LW-1:0];
        tg_q <= tag_mem[tg_addr];
    end

    // memory writes
    logic          nb_we, nl_we, sp_we, tg_we;
    logic [NW-1:0] nb_wa, nl_wa, sp_wa;
    logic [11:0]   nb_wd;
    logic [LW-1:0] nl_wd;
    logic [NW-1:0] sp_wd;
    logic [bal_pkg::TagW-1:0] tg_wa;
    logic [OW-1:0] tg_wd;

    always_ff @(posedge aclk) begin
        if (nb_we) node_block_mem[nb_wa] <= nb_wd;
        if (nl_we) node_link_mem[nl_wa] <= nl_wd;
        if (sp_we) spare_mem[sp_wa] <= sp_wd;
        if (tg_we) tag_mem[tg_wa] <= tg_wd;
    end

    always_comb begin
        nb_we = 1'b0; nb_wa = spare_node; nb_wd = off_reg;
        nl_we = 1'b0; nl_wa = spare_node; nl_wd = list_head_reg[o_reg];
        sp_we = 1'b0; sp_wa = NW'(spare_top_reg - 1'b1); sp_wd = n_reg[NW-1:0];
        tg_we = 1'b0; tg_wa = off_reg[11:2]; tg_wd = o_reg;
        unique case (state_reg)
            ST_CLR: begin
                // whole heap tagged at slot 0; node 0 holds offset 0 and the null link
                tg_we = 1'b1; tg_wa = clr_reg;
                tg_wd = (clr_reg == '0) ? OW'(HO) : '0;
                nb_we = (clr_reg == '0); nb_wa = '0; nb_wd = '0;
                nl_we = nb_we; nl_wa = '0; nl_wd = bal_pkg::NIL_NODE;
            end
            ST_GIVE: begin
                sp_we = (spare_top_reg != '0);
            end
            ST_SPL2: begin
                tg_we = 1'b1; tg_wa = buddy[11:2]; tg_wd = h_reg;
                nb_we = (spare_top_reg < (LW+1)'(bal_pkg::NodeCount));
                nl_we = nb_we;
                nb_wd = buddy;
                nl_wd = list_head_reg[h_reg];
            end
            ST_PUSH2: begin
                tg_we = 1'b1;
                nb_we = (spare_top_reg < (LW+1)'(bal_pkg::NodeCount));
                nl_we = nb_we;
            end
            ST_FUNL: begin
                nl_we = (prev_reg != bal_pkg::NIL_NODE);
                nl_wa = prev_reg[NW-1:0];
                nl_wd = nl_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
            spare_top_reg <= (LW+1)'(1);
            fill_reg <= '0;
            for (int i = 0; i <= HO; i++) begin
                list_head_reg[i] <= (i == HO) ? '0 : bal_pkg::NIL_NODE;
            end
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (sp_we && {1'b0, sp_wa} >= fill_reg) fill_reg <= LW'(sp_wa) + 1'b1;
            unique case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        kind_reg <= s_data.kind;
                        size_reg <= s_data.size;
                        off_reg <= s_data.address - 12'd4;
                        ok_reg <= 1'b0;
                        state_reg <= (s_data.kind == bal_pkg::KIND_FREE) ? ST_FTAG : ST_ASIZE;
                    end
                end
                ST_ASIZE: begin
                    o_reg <= blen;
                    h_reg <= blen;
                    off_reg <= '0;
                    state_reg <= (blen > OW'(HO)) ? ST_OUT : ST_ASCAN;
                end
                ST_ASCAN: begin
                    if (list_head_reg[h_reg] != bal_pkg::NIL_NODE) begin
                        if (avail + 1'b1 >= (LW+1)'(h_reg - o_reg)) begin
                            n_reg <= list_head_reg[h_reg];
                            state_reg <= ST_APOP;
                        end else begin
                            state_reg <= ST_OUT;
                        end
                    end else if (h_reg == OW'(HO)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        h_reg <= h_reg + 1'b1;
                    end
                end
                ST_APOP: state_reg <= ST_APOP2;   // node read in flight
                ST_APOP2: begin
                    off_reg <= nb_q;
                    list_head_reg[h_reg] <= nl_q;
                    ok_reg <= 1'b1;
                    state_reg <= ST_GIVE;
                end
                ST_GIVE: begin
                    if (spare_top_reg != '0) spare_top_reg <= spare_top_reg - 1'b1;
                    if (kind_reg == bal_pkg::KIND_FREE) begin
                        off_reg <= off_reg & ~(12'd1 << o_reg);
                        o_reg <= o_reg + 1'b1;
                        state_reg <= ST_FLVL;
                    end else begin
                        state_reg <= ST_SPL0;
                    end
                end
                ST_SPL0: begin
                    if (h_reg > o_reg) begin
                        h_reg <= h_reg - 1'b1;
                        state_reg <= ST_SPL1;
                    end else begin
                        state_reg <= ST_PUSH2;   // tag only, no push for allocate
                    end
                end
                ST_SPL1: state_reg <= ST_SPL2;   // spare read in flight
                ST_SPL2: begin
                    if (spare_top_reg < (LW+1)'(bal_pkg::NodeCount)) begin
                        list_head_reg[h_reg] <= LW'(spare_node);
                        spare_top_reg <= spare_top_reg + 1'b1;
                    end
                    state_reg <= ST_SPL0;
                end
                ST_FTAG: state_reg <= ST_FTAG2;
                ST_FTAG2: begin
                    logic [OW-1:0] t;
                    t = tag_val;
                    if (t < OW'(2)) t = OW'(2);
                    if (t > OW'(HO)) t = OW'(HO);
                    o_reg <= t;
                    off_reg <= off_reg & ~((12'd1 << t) - 12'd1);
                    state_reg <= ST_FLVL;
                end
                ST_FLVL: begin
                    h_reg <= o_reg;
                    prev_reg <= bal_pkg::NIL_NODE;
                    n_reg <= list_head_reg[o_reg];
                    steps_reg <= '0;
                    state_reg <= (o_reg >= OW'(HO)) ? ST_PUSH0 : ST_FRD;
                end
                ST_FRD: begin
                    state_reg <= (n_reg == bal_pkg::NIL_NODE) ? ST_PUSH0 : ST_FCHK;
                end
                ST_FCHK: begin
                    if (nb_q == buddy) begin
                        state_reg <= ST_FUNL;
                    end else begin
                        prev_reg <= n_reg;
                        n_reg <= nl_q;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= (steps_reg + 1'b1 >= (LW+1)'(bal_pkg::NodeCount)) ?
                                     ST_PUSH0 : ST_FRD;
                    end
                end
                ST_FUNL: begin
                    if (prev_reg == bal_pkg::NIL_NODE) list_head_reg[o_reg] <= nl_q;
                    state_reg <= ST_GIVE;
                end
                ST_PUSH0: state_reg <= ST_PUSH1;
                ST_PUSH1: state_reg <= ST_PUSH2;  // spare read in flight
                ST_PUSH2: begin
                    if (kind_reg == bal_pkg::KIND_FREE) begin
                        if (spare_top_reg < (LW+1)'(bal_pkg::NodeCount)) begin
                            list_head_reg[o_reg] <= LW'(spare_node);
                            spare_top_reg <= spare_top_reg + 1'b1;
                            ok_reg <= 1'b1;
                        end else begin
                            ok_reg <= 1'b0;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && !m_valid_reg) begin
            out_reg.ok <= ok_reg;
            out_reg.address_res <= (kind_reg == bal_pkg::KIND_ALLOC && ok_reg) ?
                                   off_reg + 12'd4 : 12'd0;
            out_reg.order <= (kind_reg == bal_pkg::KIND_ALLOC && !ok_reg) ? '0 : o_reg;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("result dropped while stalled");
    a_top_range: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_top_reg <= (LW+1)'(bal_pkg::NodeCount))
        else $error("spare top out of range");
    a_order_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> out_reg.order <= OW'(HO))
        else $error("result order out of range");
`endif
endmodule
`default_nettype wire

### dv/tb_buddy_allocator.sv
// Testbench: buddy allocator checked against a behavioral model of its free lists.
`timescale 1ns / 1ps
`default_nettype none
module tb_buddy_allocator;
    localparam int HeapOrder = bal_pkg::HeapOrder;
    localparam int NodeCount = bal_pkg::NodeCount;
    localparam int TagCount = bal_pkg::TagCount;
    localparam int RandItems = 1000;
    localparam int CycleLimit = 10000000;
    localparam int DrainCycles = 200;
    localparam int HeapMask = (1 << HeapOrder) - 1;
    localparam int HdrBytes = 4;
    localparam int MinOrder = 2;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    bal_pkg::req_t   s_data;
    logic   m_valid;
    logic   m_ready;
    bal_pkg::resp_t  m_data;

    buddy_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Model state of the heap
    int unsigned blk_off [NodeCount];
    int unsigned blk_link [NodeCount];
    int unsigned free_head [HeapOrder + 1];
    int unsigned spare_pool [NodeCount];
    int unsigned spare_idx;
    int unsigned order_tag [TagCount];

    bal_pkg::req_t   pending_reqs [$];
    bal_pkg::resp_t  expected_resps [$];
    int unsigned live_addrs [$];
    int     errors;
    int     cycles;
    int     send_idle_pct;
    int     recv_idle_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void heap_reset();
        for (int i = 0; i < NodeCount; i++) begin
            blk_off[i] = 0;
            blk_link[i] = 0;
            spare_pool[i] = i;
        end
        for (int i = 0; i < TagCount; i++) order_tag[i] = 0;
        for (int i = 0; i <= HeapOrder; i++) free_head[i] = NodeCount;
        blk_link[0] = NodeCount;
        free_head[HeapOrder] = 0;
        spare_idx = 1;
        order_tag[0] = HeapOrder;
    endfunction

    function automatic bit node_take(output int unsigned n);
        if (spare_idx >= NodeCount) return 1'b0;
        n = spare_pool[spare_idx];
        spare_idx++;
        return 1'b1;
    endfunction

    function automatic void node_give(int unsigned n);
        if (spare_idx == 0) return;
        spare_idx--;
        spare_pool[spare_idx] = n;
    endfunction

    function automatic bit list_push(int unsigned ord, int unsigned off);
        int unsigned n;
        if (!node_take(n)) return 1'b0;
        blk_off[n] = off;
        blk_link[n] = free_head[ord];
        free_head[ord] = n;
        return 1'b1;
    endfunction

    function automatic bit list_unlink(int unsigned ord, int unsigned off);
        int unsigned prev;
        int unsigned n;
        int unsigned steps;
        prev = NodeCount;
        n = free_head[ord];
        steps = 0;
        while (n < NodeCount && steps < NodeCount) begin
            if (blk_off[n] == off) begin
                if (prev == NodeCount) free_head[ord] = blk_link[n];
                else blk_link[prev] = blk_link[n];
                node_give(n);
                return 1'b1;
            end
            prev = n;
            n = blk_link[n];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic void tag_set(int unsigned off, int unsigned ord);
        order_tag[(off & HeapMask) >> 2] = ord;
    endfunction

    function automatic bal_pkg::resp_t heap_step(bal_pkg::req_t rq);
        bal_pkg::resp_t r;
        int unsigned v;
        int unsigned o;
        int unsigned h;
        int unsigned n;
        int unsigned off;
        int unsigned avail;
        r = '0;
        if (rq.kind == bal_pkg::KIND_ALLOC) begin
            v = rq.size + 3;
            o = 0;
            while (v != 0) begin
                o++;
                v >>= 1;
            end
            if (o <= HeapOrder) begin
                h = o;
                while (h <= HeapOrder && free_head[h] >= NodeCount) h++;
                avail = (spare_idx <= NodeCount) ? NodeCount - spare_idx : 0;
                if (h <= HeapOrder && avail + 1 >= h - o) begin
                    n = free_head[h];
                    off = blk_off[n] & HeapMask;
                    free_head[h] = blk_link[n];
                    node_give(n);
                    for (int unsigned k = h; k > o; k--) begin
                        tag_set(off ^ (1 << (k - 1)), k - 1);
                        void'(list_push(k - 1, off ^ (1 << (k - 1))));
                    end
                    tag_set(off, o);
                    r.address_res = 12'(off + HdrBytes);
                    r.ok = 1'b1;
                    r.order = 4'(o);
                end
            end
        end else begin
            off = (rq.address - HdrBytes) & HeapMask;
            o = order_tag[off >> 2];
            if (o < MinOrder) o = MinOrder;
            if (o > HeapOrder) o = HeapOrder;
            off &= ~((1 << o) - 1);
            while (o < HeapOrder && list_unlink(o, off ^ (1 << o))) begin
                off &= ~(1 << o);
                o++;
            end
            tag_set(off, o);
            r.ok = list_push(o, off);
            r.order = 4'(o);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // Driver: present the next item, hold it until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_reqs.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on each accepted request, check each accepted response
    always @(posedge aclk) begin
        bal_pkg::resp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = heap_step(s_data);
                expected_resps.push_back(want);
                if (s_data.kind == bal_pkg::KIND_ALLOC && want.ok)
                    live_addrs.push_back(want.address_res);
            end
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected response, ok", m_data.ok, 0);
                end else begin
                    want = expected_resps.pop_front();
                    if (m_data.address_res !== want.address_res)
                        report_mismatch("address_res", m_data.address_res, want.address_res);
                    if (m_data.ok !== want.ok) report_mismatch("ok", m_data.ok, want.ok);
                    if (m_data.order !== want.order)
                        report_mismatch("order", m_data.order, want.order);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(logic kind, int unsigned size, int unsigned addr);
        bal_pkg::req_t rq;
        while (pending_reqs.size() >= 2) @(posedge aclk);
        rq.kind = kind;
        rq.size = 12'(size);
        rq.address = 12'(addr);
        pending_reqs.push_back(rq);
    endtask

    // sample between edges so the driver and monitor updates have settled
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_valid || expected_resps.size() > 0)
            @(negedge aclk);
    endtask

    task automatic free_live();
        int idx;
        idx = $urandom_range(live_addrs.size() - 1);
        send(bal_pkg::KIND_FREE, $urandom, live_addrs[idx]);
        live_addrs.delete(idx);
    endtask

    initial begin
        int r;
        errors = 0;
        cycles = 0;
        send_idle_pct = 37;
        recv_idle_pct = 63;
        heap_reset();
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: whole heap, oversize, empty heap, wrapped and unaligned frees
        send(bal_pkg::KIND_ALLOC, 4093, 0);
        send(bal_pkg::KIND_ALLOC, 4095, 0);
        send(bal_pkg::KIND_ALLOC, 0, 0);
        wait_drained();
        free_live();
        send(bal_pkg::KIND_ALLOC, 0, 4095);
        send(bal_pkg::KIND_ALLOC, 1, 0);
        send(bal_pkg::KIND_ALLOC, 5, 0);
        send(bal_pkg::KIND_ALLOC, 13, 0);
        send(bal_pkg::KIND_ALLOC, 2045, 0);
        send(bal_pkg::KIND_ALLOC, 2046, 0);
        wait_drained();
        send(bal_pkg::KIND_FREE, 0, 2);
        send(bal_pkg::KIND_FREE, 0, 4095);
        send(bal_pkg::KIND_FREE, 0, 23);
        send(bal_pkg::KIND_FREE, 0, 4);
        while (live_addrs.size() > 0) free_live();
        send(bal_pkg::KIND_FREE, 4095, 4);
        wait_drained();

        for (int i = 0; i < RandItems; i++) begin
            if (i == RandItems / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 37;
            end else if (i == 2 * RandItems / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (live_addrs.size() > 0 && r < 45) begin
                free_live();
            end else if (r < 49) begin
                send(bal_pkg::KIND_FREE, $urandom, $urandom);
            end else if (r < 80) begin
                send(bal_pkg::KIND_ALLOC, $urandom_range(60), $urandom);
            end else if (r < 93) begin
                send(bal_pkg::KIND_ALLOC, $urandom_range(1000), $urandom);
            end else begin
                send(bal_pkg::KIND_ALLOC, $urandom_range(4095), $urandom);
            end
        end

        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### buddy_allocator.f
sv/bal_pkg.sv
sv/buddy_allocator.sv
dv/tb_buddy_allocator.sv
